@@ rtl/ljpf_pkg.sv @@
// -----------------------------------------------------------------------------
// ljpf_pkg: shared types and constants for the Lennard-Jones pair force block
// Field widths, wide-number sizes, the arithmetic unit request/response types
// and the sequencer state encoding.
// -----------------------------------------------------------------------------
package ljpf_pkg;

	// Particle store depth default.
	localparam int MAX_PARTICLES = 64;

	// Fixed field widths.
	localparam int POS_W   = 32;
	localparam int PAR_W   = 24;
	localparam int FORCE_W = 48;
	localparam int IDX_W   = 6;

	// Record layouts in the two particle memories.
	localparam int PREC_W = 3 * POS_W + 2 * PAR_W;
	localparam int AREC_W = 3 * FORCE_W + 1;

	// Sizes of the exact intermediate values of one pair.
	localparam int DPOS_W = POS_W + 1;        // position difference
	localparam int S2_W   = PAR_W + 1;        // sigma_i + sigma_j
	localparam int EPSP_W = 2 * PAR_W;        // epsilon product
	localparam int NUM0_W = PAR_W + 10;       // 768 * E
	localparam int SQ_W   = 2 * S2_W;         // S^2
	localparam int A_W    = 3 * SQ_W;         // (S^2)^3
	localparam int R2_W   = 66;               // sum of three 64-bit squares
	localparam int B_W    = 3 * R2_W;         // r2^3
	localparam int DIF_W  = B_W + 5;          // |A - 32 B|
	localparam int NUM_W  = NUM0_W + A_W + DIF_W - 1;
	localparam int DEN_W  = 2 * B_W + R2_W;

	// Width of the shared wide arithmetic unit.
	localparam int BIG_W = 512;

	// Quotient bits per force component; the top bit marks saturation.
	localparam int QUO_W  = FORCE_W;
	localparam int DIV_SH = FORCE_W - 1;

	localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
	localparam logic [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

	// Operations of the shared unit.
	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SUB
	} ljpf_op_t;

	typedef struct packed {
		logic     go;
		ljpf_op_t op;
	} ljpf_req_t;

	typedef struct packed {
		logic done;
		logic neg;
	} ljpf_rsp_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_I,
		ST_RD_J,
		ST_DIFF,
		ST_CHK,
		ST_EPSP,
		ST_SQRT,
		ST_ZCHK,
		ST_SQ,
		ST_S2SQ,
		ST_A1,
		ST_A2,
		ST_B1,
		ST_B2,
		ST_CMP,
		ST_CMP2,
		ST_ZDIF,
		ST_N1,
		ST_N2,
		ST_D1,
		ST_D2,
		ST_ND,
		ST_DIV,
		ST_UPD_RI,
		ST_UPD_WI,
		ST_UPD_RJ,
		ST_UPD_WJ,
		ST_NEXT,
		ST_OUT,
		ST_DRAIN
	} ljpf_state_t;

endpackage

@@ rtl/ljpf_ram.sv @@
// -----------------------------------------------------------------------------
// ljpf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// -----------------------------------------------------------------------------
module ljpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/ljpf_bigunit.sv @@
// -----------------------------------------------------------------------------
// ljpf_bigunit: shared wide arithmetic unit
// One wide adder does shift-add multiplication (one multiplier bit per cycle),
// restoring division (one quotient bit per cycle) and subtraction with sign.
// -----------------------------------------------------------------------------
module ljpf_bigunit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ljpf_pkg::ljpf_req_t          req,
	input  logic [ljpf_pkg::BIG_W-1:0]   opa,
	input  logic [ljpf_pkg::BIG_W-1:0]   opb,
	output logic [ljpf_pkg::BIG_W-1:0]   res,
	output logic [ljpf_pkg::QUO_W-1:0]   quo,
	output ljpf_pkg::ljpf_rsp_t          rsp
);

	localparam int CNT_W = $clog2(ljpf_pkg::QUO_W + 1);

	logic                          run_q;
	logic                          done_q;
	logic                          neg_q;
	ljpf_pkg::ljpf_op_t            op_q;
	logic [ljpf_pkg::BIG_W-1:0]    acc_q;
	logic [ljpf_pkg::BIG_W-1:0]    opx_q;
	logic [ljpf_pkg::BIG_W-1:0]    opy_q;
	logic [ljpf_pkg::QUO_W-1:0]    quo_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          sub;
	logic [ljpf_pkg::BIG_W:0]      sum;
	logic                          ge;

	// The single wide adder; subtraction adds the complement plus one.
	assign sub = (op_q != ljpf_pkg::OP_MUL);
	assign sum = {1'b0, acc_q} + {1'b0, (sub ? ~opx_q : opx_q)}
		+ (ljpf_pkg::BIG_W + 1)'(sub);
	assign ge  = sum[ljpf_pkg::BIG_W];

	assign res      = acc_q;
	assign quo      = quo_q;
	assign rsp.done = done_q;
	assign rsp.neg  = neg_q;

	// Control: run flag and the one-cycle completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
			end else if (run_q) begin
				case (op_q)
					ljpf_pkg::OP_MUL: begin
						if (opy_q == '0) begin
							run_q  <= 1'b0;
							done_q <= 1'b1;
						end
					end
					ljpf_pkg::OP_DIV: begin
						if (cnt_q == CNT_W'(1)) begin
							run_q  <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	// Datapath: operand load on a request, one step per cycle afterwards.
	always_ff @(posedge clk) begin
		if (req.go) begin
			op_q  <= req.op;
			cnt_q <= CNT_W'(ljpf_pkg::QUO_W);
			case (req.op)
				ljpf_pkg::OP_MUL: begin
					acc_q <= '0;
					opx_q <= opa;
					opy_q <= opb;
				end
				ljpf_pkg::OP_DIV: begin
					acc_q <= opa;
					opx_q <= opb << ljpf_pkg::DIV_SH;
				end
				default: begin
					acc_q <= opa;
					opx_q <= opb;
				end
			endcase
		end else if (run_q) begin
			case (op_q)
				ljpf_pkg::OP_MUL: begin
					if (opy_q != '0) begin
						if (opy_q[0]) begin
							acc_q <= sum[ljpf_pkg::BIG_W-1:0];
						end
						opx_q <= opx_q << 1;
						opy_q <= opy_q >> 1;
					end
				end
				ljpf_pkg::OP_DIV: begin
					if (ge) begin
						acc_q <= sum[ljpf_pkg::BIG_W-1:0];
					end
					quo_q <= {quo_q[ljpf_pkg::QUO_W-2:0], ge};
					opx_q <= opx_q >> 1;
					cnt_q <= cnt_q - CNT_W'(1);
				end
				default: begin
					acc_q <= sum[ljpf_pkg::BIG_W-1:0];
					neg_q <= ~ge;
				end
			endcase
		end
	end

endmodule

@@ rtl/lennard_jones_pair_forces_top.sv @@
// -----------------------------------------------------------------------------
// lennard_jones_pair_forces_top: all-pairs Lennard-Jones force accumulator
// Loads particles one per request, then on the last one evaluates every
// unordered pair exactly in wide fixed point and streams out the forces.
// -----------------------------------------------------------------------------
//
// Channel   | Handshake                  | Payload
// ----------+----------------------------+--------------------------------------
// request   | start, accepted when !busy | pos_x/y/z, sigma_in, epsilon_in,
//           |                            | start_force_x/y/z, last_particle
// result    | result_valid, one cycle    | force_x/y/z, particle_index,
//           |                            | range_fault, last_result
//
// A particle that does not close the set is stored while busy stays low. The closing
// request runs the pair loop: a coincident pair skips the arithmetic, a pair with
// zero sigma or epsilon ends after the epsilon product and its square root, and
// a full evaluation is paced by the bit-serial multiplies and the 48-step
// divisions on the one wide adder; the forces then follow one per cycle. busy
// stays high from the closing request until the last result has shown. Reset
// clears the control state only; the receiver cannot stall.
// -----------------------------------------------------------------------------
module lennard_jones_pair_forces_top #(
	parameter int MAX_PARTICLES = ljpf_pkg::MAX_PARTICLES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [ljpf_pkg::POS_W-1:0]   pos_x,
	input  logic signed [ljpf_pkg::POS_W-1:0]   pos_y,
	input  logic signed [ljpf_pkg::POS_W-1:0]   pos_z,
	input  logic [ljpf_pkg::PAR_W-1:0]          sigma_in,
	input  logic [ljpf_pkg::PAR_W-1:0]          epsilon_in,
	input  logic signed [ljpf_pkg::FORCE_W-1:0] start_force_x,
	input  logic signed [ljpf_pkg::FORCE_W-1:0] start_force_y,
	input  logic signed [ljpf_pkg::FORCE_W-1:0] start_force_z,
	input  logic                                last_particle,
	output logic                                result_valid,
	output logic signed [ljpf_pkg::FORCE_W-1:0] force_x,
	output logic signed [ljpf_pkg::FORCE_W-1:0] force_y,
	output logic signed [ljpf_pkg::FORCE_W-1:0] force_z,
	output logic [ljpf_pkg::IDX_W-1:0]          particle_index,
	output logic                                range_fault,
	output logic                                last_result
);

	localparam int AW = $clog2(MAX_PARTICLES);
	localparam int CW = AW + 1;
	localparam int FW = ljpf_pkg::FORCE_W;
	localparam int PW = ljpf_pkg::POS_W;
	localparam int QW = ljpf_pkg::PAR_W;
	localparam int DW = ljpf_pkg::DPOS_W;
	localparam int BW = ljpf_pkg::BIG_W;
	localparam int SQRT_W = ljpf_pkg::EPSP_W;

	ljpf_pkg::ljpf_state_t state_q, state_d;

	// Sequencer counters.
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] p_q;
	logic [1:0]    comp_q;
	logic          pend_q;

	// Memory ports.
	logic                          pos_we;
	logic [AW-1:0]                 pos_waddr;
	logic [ljpf_pkg::PREC_W-1:0]   pos_wdata;
	logic [AW-1:0]                 pos_raddr;
	logic [ljpf_pkg::PREC_W-1:0]   pos_rdata;
	logic                          acc_we;
	logic [AW-1:0]                 acc_waddr;
	logic [ljpf_pkg::AREC_W-1:0]   acc_wdata;
	logic [AW-1:0]                 acc_raddr;
	logic [ljpf_pkg::AREC_W-1:0]   acc_rdata;

	// Pair operands and intermediates.
	logic signed [PW-1:0]          pi_q [3];
	logic [QW-1:0]                 sigi_q;
	logic [QW-1:0]                 epsi_q;
	logic [QW-1:0]                 epsj_q;
	logic signed [DW-1:0]          d_q [3];
	logic [DW-1:0]                 m_q [3];
	logic [ljpf_pkg::S2_W-1:0]     s2_q;
	logic [SQRT_W-1:0]             sv_q;
	logic [SQRT_W-1:0]             sres_q;
	logic [SQRT_W-1:0]             sbit_q;
	logic [QW-1:0]                 eps_q;
	logic [ljpf_pkg::NUM0_W-1:0]   num0_q;
	logic [ljpf_pkg::R2_W-1:0]     r2_q;
	logic [ljpf_pkg::SQ_W-1:0]     sq_q;
	logic [ljpf_pkg::A_W-1:0]      a_q;
	logic [ljpf_pkg::B_W-1:0]      b_q;
	logic                          rep_q;
	logic [ljpf_pkg::DIF_W-1:0]    diff_q;
	logic [ljpf_pkg::NUM_W-1:0]    num_q;
	logic [ljpf_pkg::DEN_W-1:0]    den_q;
	logic signed [FW-1:0]          val_q [3];
	logic [2:0]                    sat_q;
	logic                          coin_q;

	// Result stage.
	logic                          ovalid_q;
	logic [AW-1:0]                 oidx_q;
	logic                          olast_q;

	// Shared unit.
	ljpf_pkg::ljpf_req_t           eng_req;
	ljpf_pkg::ljpf_rsp_t           eng_rsp;
	logic [BW-1:0]                 eng_a;
	logic [BW-1:0]                 eng_b;
	logic [BW-1:0]                 eng_res;
	logic [ljpf_pkg::QUO_W-1:0]    eng_quo;

	// Combinational helpers.
	logic                          accept;
	logic                          run_now;
	logic signed [PW-1:0]          pj [3];
	logic signed [DW-1:0]          d_c [3];
	logic [SQRT_W:0]               st_sum;
	logic                          st_ge;
	logic [FW-1:0]                 acc_f [3];
	logic [FW-1:0]                 acc_n [3];
	logic [2:0]                    clamp;
	logic signed [FW-1:0]          addv [3];
	logic signed [FW:0]            s49 [3];
	logic                          fault_n;
	logic [FW-1:0]                 mag;
	logic                          dpos;
	logic                          pair_more_j;
	logic                          pair_more_i;

	ljpf_ram #(
		.WIDTH(ljpf_pkg::PREC_W),
		.DEPTH(MAX_PARTICLES)
	) u_pos_ram (
		.clk  (clk),
		.we   (pos_we),
		.waddr(pos_waddr),
		.wdata(pos_wdata),
		.raddr(pos_raddr),
		.rdata(pos_rdata)
	);

	ljpf_ram #(
		.WIDTH(ljpf_pkg::AREC_W),
		.DEPTH(MAX_PARTICLES)
	) u_acc_ram (
		.clk  (clk),
		.we   (acc_we),
		.waddr(acc_waddr),
		.wdata(acc_wdata),
		.raddr(acc_raddr),
		.rdata(acc_rdata)
	);

	ljpf_bigunit u_bigunit (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (eng_req),
		.opa   (eng_a),
		.opb   (eng_b),
		.res   (eng_res),
		.quo   (eng_quo),
		.rsp   (eng_rsp)
	);

	// Request acceptance and the condition that closes the set.
	assign accept  = start && (state_q == ljpf_pkg::ST_IDLE);
	assign run_now = last_particle || (cnt_q == CW'(MAX_PARTICLES - 1));

	// Position differences of the pair as the j record arrives.
	always_comb begin
		pj[0] = pos_rdata[ljpf_pkg::PREC_W-1 -: PW];
		pj[1] = pos_rdata[ljpf_pkg::PREC_W-1-PW -: PW];
		pj[2] = pos_rdata[ljpf_pkg::PREC_W-1-2*PW -: PW];
		for (int c = 0; c < 3; c++) begin
			d_c[c] = {pi_q[c][PW-1], pi_q[c]} - {pj[c][PW-1], pj[c]};
		end
	end

	// One step of the integer square root of the epsilon product.
	assign st_sum = {1'b0, sres_q} + {1'b0, sbit_q};
	assign st_ge  = ({1'b0, sv_q} >= st_sum);

	// Saturating accumulator update for particle i (add) or j (subtract).
	always_comb begin
		acc_f[0] = acc_rdata[ljpf_pkg::AREC_W-1 -: FW];
		acc_f[1] = acc_rdata[ljpf_pkg::AREC_W-1-FW -: FW];
		acc_f[2] = acc_rdata[ljpf_pkg::AREC_W-1-2*FW -: FW];
		for (int c = 0; c < 3; c++) begin
			addv[c] = (state_q == ljpf_pkg::ST_UPD_WJ) ? -val_q[c] : val_q[c];
			s49[c]  = {acc_f[c][FW-1], acc_f[c]} + {addv[c][FW-1], addv[c]};
			clamp[c] = (s49[c][FW] != s49[c][FW-1]);
			if (clamp[c]) begin
				acc_n[c] = s49[c][FW] ? ljpf_pkg::FORCE_MIN : ljpf_pkg::FORCE_MAX;
			end else begin
				acc_n[c] = s49[c][FW-1:0];
			end
		end
		fault_n = acc_rdata[0] | coin_q | (|sat_q) | (|clamp);
	end

	// Signed force component from the quotient.
	assign mag  = eng_quo[ljpf_pkg::QUO_W-1] ? ljpf_pkg::FORCE_MAX
		: {1'b0, eng_quo[ljpf_pkg::QUO_W-2:0]};
	assign dpos = ~d_q[comp_q][DW-1];

	// Pair walk: next j in the row, or the next row.
	assign pair_more_j = ({1'b0, j_q} + CW'(1)) < n_q;
	assign pair_more_i = ({1'b0, i_q} + CW'(2)) < n_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ljpf_pkg::ST_IDLE: begin
				if (accept && run_now) begin
					state_d = (cnt_q == '0) ? ljpf_pkg::ST_OUT : ljpf_pkg::ST_RD_I;
				end
			end
			ljpf_pkg::ST_RD_I: state_d = ljpf_pkg::ST_RD_J;
			ljpf_pkg::ST_RD_J: state_d = ljpf_pkg::ST_DIFF;
			ljpf_pkg::ST_DIFF: state_d = ljpf_pkg::ST_CHK;
			ljpf_pkg::ST_CHK: begin
				if (d_q[0] == '0 && d_q[1] == '0 && d_q[2] == '0) begin
					state_d = ljpf_pkg::ST_UPD_RI;
				end else begin
					state_d = ljpf_pkg::ST_EPSP;
				end
			end
			ljpf_pkg::ST_EPSP: if (eng_rsp.done) state_d = ljpf_pkg::ST_SQRT;
			ljpf_pkg::ST_SQRT: if (sbit_q == '0) state_d = ljpf_pkg::ST_ZCHK;
			ljpf_pkg::ST_ZCHK: begin
				if (s2_q == '0 || eps_q == '0) begin
					state_d = ljpf_pkg::ST_NEXT;
				end else begin
					state_d = ljpf_pkg::ST_SQ;
				end
			end
			ljpf_pkg::ST_SQ: begin
				if (eng_rsp.done && comp_q == 2'd2) state_d = ljpf_pkg::ST_S2SQ;
			end
			ljpf_pkg::ST_S2SQ: if (eng_rsp.done) state_d = ljpf_pkg::ST_A1;
			ljpf_pkg::ST_A1:   if (eng_rsp.done) state_d = ljpf_pkg::ST_A2;
			ljpf_pkg::ST_A2:   if (eng_rsp.done) state_d = ljpf_pkg::ST_B1;
			ljpf_pkg::ST_B1:   if (eng_rsp.done) state_d = ljpf_pkg::ST_B2;
			ljpf_pkg::ST_B2:   if (eng_rsp.done) state_d = ljpf_pkg::ST_CMP;
			ljpf_pkg::ST_CMP: begin
				if (eng_rsp.done) begin
					state_d = eng_rsp.neg ? ljpf_pkg::ST_CMP2 : ljpf_pkg::ST_ZDIF;
				end
			end
			ljpf_pkg::ST_CMP2: if (eng_rsp.done) state_d = ljpf_pkg::ST_ZDIF;
			ljpf_pkg::ST_ZDIF: begin
				state_d = (diff_q == '0) ? ljpf_pkg::ST_NEXT : ljpf_pkg::ST_N1;
			end
			ljpf_pkg::ST_N1: if (eng_rsp.done) state_d = ljpf_pkg::ST_N2;
			ljpf_pkg::ST_N2: if (eng_rsp.done) state_d = ljpf_pkg::ST_D1;
			ljpf_pkg::ST_D1: if (eng_rsp.done) state_d = ljpf_pkg::ST_D2;
			ljpf_pkg::ST_D2: if (eng_rsp.done) state_d = ljpf_pkg::ST_ND;
			ljpf_pkg::ST_ND: begin
				if (m_q[comp_q] == '0) begin
					state_d = (comp_q == 2'd2) ? ljpf_pkg::ST_UPD_RI : ljpf_pkg::ST_ND;
				end else if (eng_rsp.done) begin
					state_d = ljpf_pkg::ST_DIV;
				end
			end
			ljpf_pkg::ST_DIV: begin
				if (eng_rsp.done) begin
					state_d = (comp_q == 2'd2) ? ljpf_pkg::ST_UPD_RI : ljpf_pkg::ST_ND;
				end
			end
			ljpf_pkg::ST_UPD_RI: state_d = ljpf_pkg::ST_UPD_WI;
			ljpf_pkg::ST_UPD_WI: state_d = ljpf_pkg::ST_UPD_RJ;
			ljpf_pkg::ST_UPD_RJ: state_d = ljpf_pkg::ST_UPD_WJ;
			ljpf_pkg::ST_UPD_WJ: state_d = ljpf_pkg::ST_NEXT;
			ljpf_pkg::ST_NEXT: begin
				if (pair_more_j || pair_more_i) begin
					state_d = ljpf_pkg::ST_RD_I;
				end else begin
					state_d = ljpf_pkg::ST_OUT;
				end
			end
			ljpf_pkg::ST_OUT: begin
				if (({1'b0, p_q} + CW'(1)) == n_q) state_d = ljpf_pkg::ST_DRAIN;
			end
			ljpf_pkg::ST_DRAIN: state_d = ljpf_pkg::ST_IDLE;
			default: state_d = ljpf_pkg::ST_IDLE;
		endcase
	end

	// Output logic: memory ports and shared unit requests.
	always_comb begin
		pos_we    = accept;
		pos_waddr = cnt_q[AW-1:0];
		pos_wdata = {pos_x, pos_y, pos_z, sigma_in, epsilon_in};
		pos_raddr = i_q;
		acc_we    = accept;
		acc_waddr = cnt_q[AW-1:0];
		acc_wdata = {start_force_x, start_force_y, start_force_z, 1'b0};
		acc_raddr = i_q;
		eng_req.go = 1'b0;
		eng_req.op = ljpf_pkg::OP_MUL;
		eng_a      = '0;
		eng_b      = '0;
		unique case (state_q)
			ljpf_pkg::ST_RD_J: pos_raddr = j_q;
			ljpf_pkg::ST_EPSP: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(epsi_q);
				eng_b      = BW'(epsj_q);
			end
			ljpf_pkg::ST_SQ: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(m_q[comp_q]);
				eng_b      = BW'(m_q[comp_q]);
			end
			ljpf_pkg::ST_S2SQ: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(s2_q);
				eng_b      = BW'(s2_q);
			end
			ljpf_pkg::ST_A1: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(sq_q);
				eng_b      = BW'(sq_q);
			end
			ljpf_pkg::ST_A2: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(a_q);
				eng_b      = BW'(sq_q);
			end
			ljpf_pkg::ST_B1: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(r2_q);
				eng_b      = BW'(r2_q);
			end
			ljpf_pkg::ST_B2: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(b_q);
				eng_b      = BW'(r2_q);
			end
			ljpf_pkg::ST_CMP: begin
				eng_req.go = ~pend_q;
				eng_req.op = ljpf_pkg::OP_SUB;
				eng_a      = BW'(a_q);
				eng_b      = BW'(b_q) << 5;
			end
			ljpf_pkg::ST_CMP2: begin
				eng_req.go = ~pend_q;
				eng_req.op = ljpf_pkg::OP_SUB;
				eng_a      = BW'(b_q) << 5;
				eng_b      = BW'(a_q);
			end
			ljpf_pkg::ST_N1: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(a_q);
				eng_b      = BW'(num0_q);
			end
			ljpf_pkg::ST_N2: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(num_q);
				eng_b      = BW'(diff_q);
			end
			ljpf_pkg::ST_D1: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(b_q);
				eng_b      = BW'(b_q);
			end
			ljpf_pkg::ST_D2: begin
				eng_req.go = ~pend_q;
				eng_a      = BW'(den_q);
				eng_b      = BW'(r2_q);
			end
			ljpf_pkg::ST_ND: begin
				eng_req.go = ~pend_q && (m_q[comp_q] != '0);
				eng_a      = BW'(num_q);
				eng_b      = BW'(m_q[comp_q]);
			end
			ljpf_pkg::ST_DIV: begin
				eng_req.go = ~pend_q;
				eng_req.op = ljpf_pkg::OP_DIV;
				eng_a      = eng_res;
				eng_b      = BW'(den_q);
			end
			ljpf_pkg::ST_UPD_WI: begin
				acc_we    = 1'b1;
				acc_waddr = i_q;
				acc_wdata = {acc_n[0], acc_n[1], acc_n[2], fault_n};
			end
			ljpf_pkg::ST_UPD_RJ: acc_raddr = j_q;
			ljpf_pkg::ST_UPD_WJ: begin
				acc_raddr = j_q;
				acc_we    = 1'b1;
				acc_waddr = j_q;
				acc_wdata = {acc_n[0], acc_n[1], acc_n[2], fault_n};
			end
			ljpf_pkg::ST_OUT: acc_raddr = p_q;
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ljpf_pkg::ST_IDLE;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ovalid_q <= (state_q == ljpf_pkg::ST_OUT);
			if (eng_req.go) begin
				pend_q <= 1'b1;
			end else if (eng_rsp.done) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				cnt_q <= run_now ? '0 : cnt_q + CW'(1);
			end
		end
	end

	// Datapath registers, loaded by state.
	always_ff @(posedge clk) begin
		oidx_q  <= p_q;
		olast_q <= (({1'b0, p_q} + CW'(1)) == n_q);
		case (state_q)
			ljpf_pkg::ST_IDLE: begin
				if (accept) begin
					n_q <= cnt_q + CW'(1);
					i_q <= '0;
					j_q <= AW'(1);
					p_q <= '0;
				end
			end
			ljpf_pkg::ST_RD_J: begin
				pi_q[0] <= pos_rdata[ljpf_pkg::PREC_W-1 -: PW];
				pi_q[1] <= pos_rdata[ljpf_pkg::PREC_W-1-PW -: PW];
				pi_q[2] <= pos_rdata[ljpf_pkg::PREC_W-1-2*PW -: PW];
				sigi_q  <= pos_rdata[2*QW-1 -: QW];
				epsi_q  <= pos_rdata[QW-1:0];
			end
			ljpf_pkg::ST_DIFF: begin
				for (int c = 0; c < 3; c++) begin
					d_q[c] <= d_c[c];
					m_q[c] <= d_c[c][DW-1] ? DW'(-d_c[c]) : DW'(d_c[c]);
				end
				s2_q   <= {1'b0, sigi_q} + {1'b0, pos_rdata[2*QW-1 -: QW]};
				epsj_q <= pos_rdata[QW-1:0];
			end
			ljpf_pkg::ST_CHK: begin
				coin_q <= (d_q[0] == '0 && d_q[1] == '0 && d_q[2] == '0);
				sat_q  <= '0;
				for (int c = 0; c < 3; c++) begin
					val_q[c] <= '0;
				end
			end
			ljpf_pkg::ST_EPSP: begin
				if (eng_rsp.done) begin
					sv_q   <= eng_res[SQRT_W-1:0];
					sres_q <= '0;
					sbit_q <= SQRT_W'(1) << (SQRT_W - 2);
				end
			end
			ljpf_pkg::ST_SQRT: begin
				if (sbit_q != '0) begin
					if (st_ge) begin
						sv_q   <= sv_q - st_sum[SQRT_W-1:0];
						sres_q <= (sres_q >> 1) + sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end else begin
					eps_q <= sres_q[QW-1:0];
				end
			end
			ljpf_pkg::ST_ZCHK: begin
				// 768 * E as two shifted copies.
				num0_q <= {1'b0, eps_q, 9'b0} + {2'b0, eps_q, 8'b0};
				r2_q   <= '0;
				comp_q <= '0;
			end
			ljpf_pkg::ST_SQ: begin
				// Each square fits in 64 bits and is added into the sum.
				if (eng_rsp.done) begin
					r2_q   <= r2_q + ljpf_pkg::R2_W'(eng_res[63:0]);
					comp_q <= comp_q + 2'd1;
				end
			end
			ljpf_pkg::ST_S2SQ: if (eng_rsp.done) sq_q <= eng_res[ljpf_pkg::SQ_W-1:0];
			ljpf_pkg::ST_A1:   if (eng_rsp.done) a_q <= eng_res[ljpf_pkg::A_W-1:0];
			ljpf_pkg::ST_A2:   if (eng_rsp.done) a_q <= eng_res[ljpf_pkg::A_W-1:0];
			ljpf_pkg::ST_B1:   if (eng_rsp.done) b_q <= eng_res[ljpf_pkg::B_W-1:0];
			ljpf_pkg::ST_B2:   if (eng_rsp.done) b_q <= eng_res[ljpf_pkg::B_W-1:0];
			ljpf_pkg::ST_CMP: begin
				if (eng_rsp.done) begin
					rep_q  <= 1'b1;
					diff_q <= eng_res[ljpf_pkg::DIF_W-1:0];
				end
			end
			ljpf_pkg::ST_CMP2: begin
				if (eng_rsp.done) begin
					rep_q  <= 1'b0;
					diff_q <= eng_res[ljpf_pkg::DIF_W-1:0];
				end
			end
			ljpf_pkg::ST_N1: if (eng_rsp.done) num_q <= eng_res[ljpf_pkg::NUM_W-1:0];
			ljpf_pkg::ST_N2: if (eng_rsp.done) num_q <= eng_res[ljpf_pkg::NUM_W-1:0];
			ljpf_pkg::ST_D1: if (eng_rsp.done) den_q <= eng_res[ljpf_pkg::DEN_W-1:0];
			ljpf_pkg::ST_D2: begin
				if (eng_rsp.done) begin
					den_q  <= eng_res[ljpf_pkg::DEN_W-1:0];
					comp_q <= '0;
				end
			end
			ljpf_pkg::ST_ND: begin
				// An axis with no separation contributes nothing.
				if (m_q[comp_q] == '0) begin
					val_q[comp_q] <= '0;
					sat_q[comp_q] <= 1'b0;
					comp_q        <= comp_q + 2'd1;
				end
			end
			ljpf_pkg::ST_DIV: begin
				if (eng_rsp.done) begin
					val_q[comp_q] <= (rep_q == dpos) ? mag : -mag;
					sat_q[comp_q] <= eng_quo[ljpf_pkg::QUO_W-1];
					comp_q        <= comp_q + 2'd1;
				end
			end
			ljpf_pkg::ST_NEXT: begin
				if (pair_more_j) begin
					j_q <= j_q + AW'(1);
				end else begin
					i_q <= i_q + AW'(1);
					j_q <= i_q + AW'(2);
				end
			end
			ljpf_pkg::ST_OUT: begin
				p_q <= p_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	// Result ports: strobe and index registered, record from the read port.
	assign busy           = (state_q != ljpf_pkg::ST_IDLE);
	assign result_valid   = ovalid_q;
	assign force_x        = acc_rdata[ljpf_pkg::AREC_W-1 -: FW];
	assign force_y        = acc_rdata[ljpf_pkg::AREC_W-1-FW -: FW];
	assign force_z        = acc_rdata[ljpf_pkg::AREC_W-1-2*FW -: FW];
	assign range_fault    = acc_rdata[0];
	assign particle_index = ljpf_pkg::IDX_W'(oidx_q);
	assign last_result    = olast_q;

endmodule
